// ----- hdl/icv_pkg.sv -----
// shared types and constants for the integer 2d convolution block
// no dependencies; used by every module under hdl but icv_check

package icv_pkg;

    localparam int QDEPTH = 4;
    localparam int QLW    = $clog2(QDEPTH + 1);
    localparam int QAW    = $clog2(QDEPTH);

    localparam int DW        = 64;
    localparam int ROW_W     = 13;
    localparam int OROW_W    = 12;
    localparam int OCOL_W    = 8;
    localparam int IDX_W     = 6;
    localparam int MAX_ROWS  = 4096;
    localparam int GROUP     = 8;

    localparam logic CFG_OUT_COLS = 1'b0;
    localparam logic CFG_OUT_ROWS = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_COEF  = 1'b1;

    // per-item control word passed from the front end to the datapath
    typedef struct packed {
        logic                is_coef;
        logic [IDX_W-1:0]    idx;
        logic                emit;
        logic [OROW_W-1:0]   row;
        logic [OCOL_W-1:0]   col;
        logic                last;
    } t_meta;

    localparam int META_W = $bits(t_meta);

endpackage

// ----- hdl/icv_front.sv -----
// front end: config registers, frame counters, line store, column build
// depends on icv_pkg

module icv_front #(
    parameter int FS       = 7,
    parameter int MAX_COLS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_index,
    input  logic [12:0]              i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_func,
    input  logic [63:0]              i_value,
    input  logic [5:0]               i_coef_index,
    input  logic [icv_pkg::QLW-1:0]  i_level,
    output logic                     o_push,
    output logic [FS*64-1:0]         o_column,
    output icv_pkg::t_meta           o_meta
);

    localparam int CNTW = $clog2(MAX_COLS + 1);
    localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EW   = CNTW + 8;
    localparam int MW   = (FS > 1) ? FS - 1 : 1;
    localparam int QLW1 = icv_pkg::QLW + 1;

    logic [7:0]            r_out_cols;
    logic [12:0]           r_out_rows;
    logic [CNTW-1:0]       r_col;
    logic [12:0]           r_row;

    logic                  r_s1_valid;
    logic                  r_s1_coef;
    logic [63:0]           r_s1_value;
    logic [5:0]            r_s1_idx;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_s1_emit;
    logic [11:0]           r_s1_row;
    logic [7:0]            r_s1_col;
    logic                  r_s1_last;
    logic [MW*64-1:0]      r_rd;
    logic [MW*64-1:0]      r_line [MAX_COLS];

    logic                  v_acc;
    logic [EW-1:0]         v_oc, v_effc, v_w, v_c, v_nc;
    logic [13:0]           v_or, v_effr, v_h, v_rr, v_r, v_nr;
    logic [EW-1:0]         n_col;
    logic [13:0]           n_row;
    logic                  v_emit, v_last;
    logic [FS*64-1:0]      v_column;
    logic [MW*64-1:0]      v_wr;

    assign o_ready = (({1'b0, i_level}) + (QLW1)'(r_s1_valid)) < (QLW1)'(icv_pkg::QDEPTH);
    assign v_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cols <= 8'd250;
            r_out_rows <= 13'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                icv_pkg::CFG_OUT_COLS: r_out_cols <= i_cfg_data[7:0];
                icv_pkg::CFG_OUT_ROWS: r_out_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes and the position of this pixel after folding
    always_comb begin
        v_oc = EW'(r_out_cols);
        if (v_oc == '0)                        v_effc = EW'(1);
        else if (v_oc > EW'(MAX_COLS - FS + 1)) v_effc = EW'(MAX_COLS - FS + 1);
        else                                   v_effc = v_oc;
        v_w = v_effc + EW'(FS - 1);

        v_or = 14'(r_out_rows);
        if (v_or == '0)                         v_effr = 14'd1;
        else if (v_or > 14'(icv_pkg::MAX_ROWS)) v_effr = 14'(icv_pkg::MAX_ROWS);
        else                                    v_effr = v_or;
        v_h = v_effr + 14'(FS - 1);

        if (EW'(r_col) >= v_w) begin
            v_c  = '0;
            v_rr = 14'(r_row) + 14'd1;
        end else begin
            v_c  = EW'(r_col);
            v_rr = 14'(r_row);
        end
        v_r = (v_rr >= v_h) ? '0 : v_rr;

        v_nc = v_c + EW'(1);
        if (v_nc >= v_w) begin
            n_col = '0;
            v_nr  = v_r + 14'd1;
            n_row = (v_nr >= v_h) ? '0 : v_nr;
        end else begin
            v_nr  = v_r;
            n_col = v_nc;
            n_row = v_r;
        end
        v_emit = (v_c >= EW'(FS - 1)) && (v_r >= 14'(FS - 1));
        v_last = (v_r == v_h - 14'd1) && (v_c == v_w - EW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= v_acc;
            if (v_acc && i_func == icv_pkg::FUNC_PIXEL) begin
                r_col <= CNTW'(n_col);
                r_row <= 13'(n_row);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_acc) begin
            r_s1_coef  <= (i_func == icv_pkg::FUNC_COEF);
            r_s1_value <= i_value;
            r_s1_idx   <= i_coef_index;
            r_s1_addr  <= AW'(v_c);
            r_s1_emit  <= v_emit;
            r_s1_row   <= 12'(v_r - 14'(FS - 1));
            r_s1_col   <= 8'(v_c - EW'(FS - 1));
            r_s1_last  <= v_last;
        end
    end

    // column: older rows from the line store, newest row is the pixel
    always_comb begin
        v_column = '0;
        v_wr     = r_rd;
        for (int k = 0; k < FS - 1; k++) begin
            v_column[k*64 +: 64] = r_rd[k*64 +: 64];
        end
        v_column[(FS-1)*64 +: 64] = r_s1_value;
        for (int k = 0; k < FS - 1; k++) begin
            v_wr[k*64 +: 64] = v_column[(k+1)*64 +: 64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_acc && i_func == icv_pkg::FUNC_PIXEL) begin
            r_rd <= r_line[AW'(v_c)];
        end
        if (r_s1_valid && !r_s1_coef) begin
            r_line[r_s1_addr] <= v_wr;
        end
    end

    assign o_push        = r_s1_valid;
    assign o_column      = v_column;
    assign o_meta.is_coef = r_s1_coef;
    assign o_meta.idx     = r_s1_idx;
    assign o_meta.emit    = r_s1_emit && !r_s1_coef;
    assign o_meta.row     = r_s1_row;
    assign o_meta.col     = r_s1_col;
    assign o_meta.last    = r_s1_last;

endmodule

// ----- hdl/icv_fifo.sv -----
// short queue between the front end and the datapath
// depends on icv_pkg for depth constants

module icv_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic                     o_valid,
    output logic [WIDTH-1:0]         o_data,
    output logic [icv_pkg::QLW-1:0]  o_level
);

    logic [WIDTH-1:0]          r_mem [icv_pkg::QDEPTH];
    logic [icv_pkg::QAW-1:0]   r_wp, r_rp;
    logic [icv_pkg::QLW-1:0]   r_cnt;
    logic                      v_pop;

    assign v_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (v_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + icv_pkg::QLW'(i_push) - icv_pkg::QLW'(v_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- hdl/icv_back.sv -----
// datapath: coefficient table, window, split multipliers and adder tree
// depends on icv_pkg

module icv_back #(
    parameter int FS = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [FS*64-1:0]   i_column,
    input  icv_pkg::t_meta     i_meta,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [63:0]        o_sum,
    output logic [11:0]        o_row,
    output logic [7:0]         o_col,
    output logic               o_last
);

    localparam int NT = FS * FS;
    localparam int NG = (NT + icv_pkg::GROUP - 1) / icv_pkg::GROUP;

    logic          v_en;
    logic [63:0]   r_win  [FS][FS];
    logic [63:0]   r_coef [NT];
    logic [63:0]   r_p0   [NT];
    logic [31:0]   r_p1   [NT];
    logic [31:0]   r_p2   [NT];
    logic [63:0]   r_prod [NT];
    logic [63:0]   r_grp  [NG];
    logic [63:0]   v_grp  [NG];
    logic [63:0]   v_total;

    logic [3:0]    r_vld;
    logic [11:0]   r_row [4];
    logic [7:0]    r_col [4];
    logic [3:0]    r_lst;

    // the whole pipe holds while a finished result waits
    assign v_en  = !o_tvalid || i_tready;
    assign o_pop = i_valid && v_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FS; k++) begin
                for (int j = 0; j < FS; j++) r_win[k][j] <= '0;
            end
        end else if (o_pop && !i_meta.is_coef) begin
            for (int k = 0; k < FS; k++) begin
                for (int j = 0; j < FS - 1; j++) r_win[k][j] <= r_win[k][j+1];
                r_win[k][FS-1] <= i_column[k*64 +: 64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_meta.is_coef && (7'(i_meta.idx) < 7'(NT))) begin
            r_coef[i_meta.idx] <= i_column[(FS-1)*64 +: 64];
        end
    end

    // low 64 bits of each product from three 32x32 partials
    for (genvar t = 0; t < NT; t++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (v_en) begin
                r_p0[t]   <= {32'd0, r_win[t/FS][t%FS][31:0]} * {32'd0, r_coef[t][31:0]};
                r_p1[t]   <= r_win[t/FS][t%FS][63:32] * r_coef[t][31:0];
                r_p2[t]   <= r_win[t/FS][t%FS][31:0] * r_coef[t][63:32];
                r_prod[t] <= r_p0[t] + {r_p1[t] + r_p2[t], 32'd0};
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            v_grp[g] = '0;
            for (int e = 0; e < icv_pkg::GROUP; e++) begin
                if (g * icv_pkg::GROUP + e < NT) begin
                    v_grp[g] = v_grp[g] + r_prod[g * icv_pkg::GROUP + e];
                end
            end
        end
        v_total = '0;
        for (int g = 0; g < NG; g++) v_total = v_total + r_grp[g];
    end

    always_ff @(posedge i_clk) begin
        if (v_en) begin
            for (int g = 0; g < NG; g++) r_grp[g] <= v_grp[g];
            o_sum <= v_total;
            o_row <= r_row[3];
            o_col <= r_col[3];
            o_last <= r_lst[3];
            r_row[0] <= i_meta.row;
            r_col[0] <= i_meta.col;
            r_lst[0] <= i_meta.last;
            for (int s = 1; s < 4; s++) begin
                r_row[s] <= r_row[s-1];
                r_col[s] <= r_col[s-1];
                r_lst[s] <= r_lst[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            o_tvalid <= 1'b0;
        end else if (v_en) begin
            r_vld    <= {r_vld[2:0], o_pop && i_meta.emit};
            o_tvalid <= r_vld[3];
        end
    end

endmodule

// ----- hdl/integer_conv2d_valid.sv -----
// top level of the integer 2d valid-region convolution
// depends on icv_pkg, icv_front, icv_fifo, icv_back

// Takes one item per clock while s_axis_tready is high: coefficient loads
// (tuser high) fill the filter table, pixels (tuser low) stream the image
// row-major, with the image (out_cols+FILTER_SIZE-1) wide and
// (out_rows+FILTER_SIZE-1) high. Each pixel that completes a window yields
// one sum of products, wrapped to 64 bits, with its row and column and
// tlast on the frame's final result. A result passes through the front-end
// register for the registered line-store read, the queue write (the
// line-store write-back happens alongside), then window, partial products,
// product combine and group add, with the final add feeding the output
// register. A four-entry queue parts front end and datapath, so input
// keeps flowing for a few words while a result waits for tready.
module integer_conv2d_valid #(
    parameter int FILTER_SIZE = 7,
    parameter int MAX_COLS    = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // value[63:0], coef_index[69:64], zero pad
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,  // sum[63:0], out_row[75:64], out_col[83:76], pad
    output logic         m_axis_tlast
);

    localparam int QW = FILTER_SIZE * 64 + icv_pkg::META_W;

    logic                       w_push, w_pop, w_qvalid;
    logic [FILTER_SIZE*64-1:0]  w_column;
    icv_pkg::t_meta             w_meta, w_qmeta;
    logic [QW-1:0]              w_qdata;
    logic [icv_pkg::QLW-1:0]    w_level;
    logic [63:0]                w_sum;
    logic [11:0]                w_row;
    logic [7:0]                 w_col;

    assign o_cfg_ready = 1'b1;

    icv_front #(.FS(FILTER_SIZE), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_value      (s_axis_tdata[63:0]),
        .i_coef_index (s_axis_tdata[69:64]),
        .i_level      (w_level),
        .o_push       (w_push),
        .o_column     (w_column),
        .o_meta       (w_meta)
    );

    icv_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_column, w_meta}),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qdata),
        .o_level (w_level)
    );

    assign w_qmeta = w_qdata[icv_pkg::META_W-1:0];

    icv_back #(.FS(FILTER_SIZE)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_column (w_qdata[QW-1:icv_pkg::META_W]),
        .i_meta   (w_qmeta),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_sum    (w_sum),
        .o_row    (w_row),
        .o_col    (w_col),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_col, w_row, w_sum};

endmodule

// ----- hdl/icv_check.sv -----
// port-level checks for integer_conv2d_valid, bound to the top level
// depends only on the top level's ports

module icv_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_cfg_ready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata,
    input logic         m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[83:76] <= 8'd249))
        else $error("output column beyond range");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind integer_conv2d_valid icv_check u_icv_check (.*);

// ----- tb/tb_integer_conv2d_valid.sv -----
`timescale 1ns / 1ps
// self-checking testbench for integer_conv2d_valid: coefficient loads and image
// frames at many sizes, with results checked against an in-bench window model
// depends on icv_pkg and the integer_conv2d_valid rtl

module tb_integer_conv2d_valid;

    localparam int FS    = 7;
    localparam int MCOLS = 256;
    localparam int NTAP  = FS * FS;

    typedef struct {
        logic        func;
        logic [63:0] value;
        logic [5:0]  idx;
    } t_item;

    typedef struct {
        logic [63:0] sum;
        logic [11:0] row;
        logic [7:0]  col;
        logic        last;
    } t_pixel_out;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [12:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tlast;

    integer_conv2d_valid #(.FILTER_SIZE(FS), .MAX_COLS(MCOLS)) dut (.*);

    // window model state
    logic [63:0] coef_tab [NTAP];
    logic [63:0] line_mem [FS-1][MCOLS];
    logic [63:0] win [FS][FS];
    int          col_cnt, row_cnt;
    int          cols_reg, rows_reg;

    t_item       pend_q [$];
    t_pixel_out  conv_q [$];
    int          errors;
    int          burst_left, gap_left;
    int          stall_left, stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("** integer_conv2d_valid: FAILED **");
        $finish;
    end

    function automatic int eff_w();
        int c;
        c = cols_reg;
        if (c == 0) c = 1;
        if (c > MCOLS - FS + 1) c = MCOLS - FS + 1;
        return c + FS - 1;
    endfunction

    function automatic int eff_h();
        int r;
        r = rows_reg;
        if (r == 0) r = 1;
        if (r > icv_pkg::MAX_ROWS) r = icv_pkg::MAX_ROWS;
        return r + FS - 1;
    endfunction

    // advance the window model by one item and queue any result
    function automatic void predict_item(t_item it);
        int          w, h, c, r;
        logic [63:0] newcol [FS];
        logic [63:0] acc;
        t_pixel_out  res;
        w = eff_w();
        h = eff_h();
        if (it.func == icv_pkg::FUNC_COEF) begin
            if (it.idx < NTAP) coef_tab[it.idx] = it.value;
            return;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        for (int k = 0; k < FS - 1; k++) newcol[k] = line_mem[k][c];
        newcol[FS-1] = it.value;
        for (int k = 0; k < FS - 1; k++) line_mem[k][c] = newcol[k+1];
        for (int k = 0; k < FS; k++) begin
            for (int j = 0; j < FS - 1; j++) win[k][j] = win[k][j+1];
            win[k][FS-1] = newcol[k];
        end
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        if (c >= FS - 1 && r >= FS - 1) begin
            acc = '0;
            for (int k = 0; k < FS; k++)
                for (int j = 0; j < FS; j++)
                    acc += win[k][j] * coef_tab[k*FS+j];
            res.sum  = acc;
            res.row  = 12'(r - (FS - 1));
            res.col  = 8'(c - (FS - 1));
            res.last = (r == h - 1 && c == w - 1);
            conv_q.push_back(res);
        end
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2, 3: return {$urandom, $urandom};
            4: return 64'($signed($urandom_range(0, 16)) - 8);
            default: return '1;
        endcase
    endfunction

    task automatic send(logic func, logic [63:0] value, logic [5:0] idx);
        t_item it;
        it.func  = func;
        it.value = value;
        it.idx   = idx;
        pend_q.push_back(it);
        predict_item(it);
    endtask

    // pixels with occasional coefficient reloads; optionally run to frame end
    task automatic send_pixels(int n, bit to_frame_end, int coef_pct);
        int sent;
        sent = 0;
        while (sent < n || (to_frame_end && (col_cnt != 0 || row_cnt != 0))) begin
            if ($urandom_range(0, 99) < coef_pct)
                send(icv_pkg::FUNC_COEF, rand_word(), 6'($urandom_range(0, 63)));
            send(icv_pkg::FUNC_PIXEL, rand_word(), '0);
            sent++;
        end
    endtask

    // block idle: all words taken, all results seen, pipeline flushed
    task automatic drain();
        int guard;
        guard = 0;
        while ((pend_q.size() != 0 || s_axis_tvalid || conv_q.size() != 0) && guard < 2_000_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == icv_pkg::CFG_OUT_COLS) cols_reg = data[7:0];
        else rows_reg = data;
        @(posedge i_clk);
    endtask

    task automatic set_size(int cols, int rows);
        write_reg(icv_pkg::CFG_OUT_COLS, 13'(cols));
        write_reg(icv_pkg::CFG_OUT_ROWS, 13'(rows));
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (pend_q.size() != 0) begin
                t_item it;
                it = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, it.idx, it.value};
                s_axis_tuser  <= it.func;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: alternates free-running stretches and choppy stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stall_mode    <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_left <= $urandom_range(10, 120);
                stall_mode <= $urandom_range(0, 2);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_pixel_out e;
            if (conv_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: sum=%h row=%0d col=%0d last=%b",
                             m_axis_tdata[63:0], m_axis_tdata[75:64],
                             m_axis_tdata[83:76], m_axis_tlast);
            end else begin
                e = conv_q.pop_front();
                if (m_axis_tdata[63:0] !== e.sum || m_axis_tdata[75:64] !== e.row
                        || m_axis_tdata[83:76] !== e.col || m_axis_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp sum=%h row=%0d col=%0d last=%b  got sum=%h row=%0d col=%0d last=%b",
                                 e.sum, e.row, e.col, e.last,
                                 m_axis_tdata[63:0], m_axis_tdata[75:64],
                                 m_axis_tdata[83:76], m_axis_tlast);
                end
            end
        end
    end

    initial begin
        int rand_pix;
        errors        = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        for (int k = 0; k < FS; k++)
            for (int j = 0; j < FS; j++) win[k][j] = '0;
        for (int k = 0; k < FS - 1; k++)
            for (int j = 0; j < MCOLS; j++) line_mem[k][j] = '0;
        foreach (coef_tab[i]) coef_tab[i] = '0;
        col_cnt  = 0;
        row_cnt  = 0;
        cols_reg = 250;
        rows_reg = 64;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small frame, full filter load with extreme taps
        set_size(3, 2);
        send(icv_pkg::FUNC_COEF, 64'h7fff_ffff_ffff_ffff, 6'd0);
        send(icv_pkg::FUNC_COEF, 64'h8000_0000_0000_0000, 6'd48);
        for (int i = 1; i < NTAP - 1; i++)
            send(icv_pkg::FUNC_COEF, 64'($signed($urandom_range(0, 10)) - 5), 6'(i));
        send(icv_pkg::FUNC_COEF, '1, 6'd49);   // out of range, ignored
        send(icv_pkg::FUNC_COEF, '1, 6'd63);
        send(icv_pkg::FUNC_PIXEL, 64'h8000_0000_0000_0000, '0);
        send(icv_pkg::FUNC_PIXEL, 64'h7fff_ffff_ffff_ffff, '0);
        send(icv_pkg::FUNC_PIXEL, '1, '0);
        send(icv_pkg::FUNC_PIXEL, '0, '0);
        send_pixels(0, 1'b1, 0);
        drain();

        // zero sizes act as one output
        set_size(0, 0);
        send_pixels(1, 1'b1, 0);
        drain();

        // random frames at small sizes with coefficient reloads
        rand_pix = 0;
        while (rand_pix < 700) begin
            set_size($urandom_range(0, 12), $urandom_range(1, 5));
            send_pixels($urandom_range(1, 120), 1'b1, 8);
            rand_pix += eff_w() * eff_h();
            drain();
        end

        // shrink the frame while one is in progress
        set_size(10, 5);
        send_pixels(100, 1'b0, 0);
        drain();
        write_reg(icv_pkg::CFG_OUT_COLS, 13'd3);
        send_pixels(20, 1'b0, 0);
        drain();
        write_reg(icv_pkg::CFG_OUT_ROWS, 13'd1);
        send_pixels(1, 1'b1, 0);
        drain();

        // oversized widths and heights clamp
        set_size(255, 1);
        send_pixels(300, 1'b0, 2);
        drain();
        set_size(0, 8191);
        send_pixels(40, 1'b0, 0);
        drain();

        if (errors == 0 && conv_q.size() == 0)
            $display("** integer_conv2d_valid: PASSED **");
        else
            $display("** integer_conv2d_valid: FAILED **");
        $finish;
    end

endmodule
